/* rtl/core/trm_pkg.sv */
package trm_pkg;

	localparam int HIST_DEPTH = 16;
	localparam int SLOT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(HIST_DEPTH + 1);
	localparam int RATE_SCALE = 10000;
	localparam int NUM_RAW_W = $clog2((HIST_DEPTH - 1) * RATE_SCALE + 1);
	localparam int NUM_W = (NUM_RAW_W > 16) ? NUM_RAW_W : 17;
	localparam int STEP_W = $clog2(NUM_W + 1);
	localparam int STAMP_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_TAP   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW   = 3'd0,
		CFG_MIN_GAP  = 3'd1,
		CFG_ON_LVL   = 3'd2,
		CFG_OFF_LVL  = 3'd3,
		CFG_DECAY    = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAP,
		ST_SCAN,
		ST_CALC,
		ST_DIV,
		ST_FLAG,
		ST_OUT
	} state_t;

endpackage

/* rtl/core/tap_rate_meter_with_hysteresis.sv */
// Tap rate meter with a high-rate flag.
// Input channel: in_valid / in_stall with opcode (tick, tap, clear) and now_ms.
// Output channel: out_valid / out_stall with rate_x10, fast_flag, tap_stored;
// exactly one output word per input word, in order.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects the
// register, cfg_data is the 16-bit value; write only while the block is idle.
// Time stamps live in a 16-entry RAM with a registered read. A tap
// reads the previous slot's stamp and, if the minimum gap is met, writes its own
// stamp to the current slot; then each word but a clear scans the RAM one entry per
// cycle, then, with two or more stamps in the window and the oldest before now_ms,
// runs a restoring divider one quotient bit per cycle, then updates the flag.
// One item is in flight at a time; the next word is taken the cycle after a
// result loads, and in_stall is high from acceptance until the result is in the
// output register. A clear skips the scan and goes straight to the output.
// A finished result waits in the output register while out_stall is high and
// the next input word is taken meanwhile; its result holds until the slot frees.
// Reset empties the ring (per-entry valid bits), zeroes rate and flag, and loads
// the default register values; no clearing pass is needed.
module tap_rate_meter_with_hysteresis (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [trm_pkg::STAMP_W-1:0]   now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   rate_x10,
	output logic                          fast_flag,
	output logic                          tap_stored,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [trm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trm_pkg::CFG_W-1:0]     cfg_data
);

	import trm_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0]   window_q, min_gap_q, on_lvl_q, off_lvl_q, decay_q;
	logic [1:0]         op_q;
	logic [STAMP_W-1:0] now_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [HIST_DEPTH-1:0] vld_q;
	logic [CNT_W-1:0]   issue_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STAMP_W-1:0] oldest_q;
	logic [15:0]        rate_q;
	logic               flag_q;
	logic [STAMP_W-1:0] since_q;
	logic               stored_q;
	logic               rsp_v_s1;
	logic [SLOT_W-1:0]  rsp_slot_s1;
	logic               out_valid_q;
	logic [15:0]        rate_out_q;
	logic               flag_out_q;
	logic               stored_out_q;

	logic               accept;
	logic               out_free;
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_raddr;
	logic [STAMP_W-1:0] ram_rdata;
	logic [SLOT_W-1:0]  prev_slot;
	logic [SLOT_W-1:0]  next_slot;
	logic [STAMP_W-1:0] prev_stamp;
	logic               gap_ok;
	logic [STAMP_W-1:0] scan_stamp;
	logic               scan_hit;
	logic               issue_more;
	logic               rate_ok;
	logic               div_start;
	logic               div_done;
	logic [NUM_W-1:0]   div_num;
	logic [NUM_W-1:0]   div_quot;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign prev_slot = (slot_q == '0) ? SLOT_W'(HIST_DEPTH - 1) : SLOT_W'(slot_q - SLOT_W'(1));
	assign next_slot = (slot_q == SLOT_W'(HIST_DEPTH - 1)) ? '0 : SLOT_W'(slot_q + SLOT_W'(1));
	assign prev_stamp = vld_q[prev_slot] ? ram_rdata : '0;
	assign gap_ok = (prev_stamp == '0) ||
		(STAMP_W'(now_q - prev_stamp) >= {16'd0, min_gap_q});

	assign scan_stamp = vld_q[rsp_slot_s1] ? ram_rdata : '0;
	assign scan_hit   = (scan_stamp != '0) &&
		(STAMP_W'(now_q - scan_stamp) <= {16'd0, window_q});
	assign issue_more = issue_q < CNT_W'(HIST_DEPTH);

	assign rate_ok = (cnt_q >= CNT_W'(2)) && (oldest_q < now_q);
	assign div_num = NUM_W'((NUM_W'(cnt_q) - NUM_W'(1)) * NUM_W'(RATE_SCALE));

	trm_ram #(
		.WIDTH(STAMP_W),
		.DEPTH(HIST_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (now_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	trm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (STAMP_W'(now_q - oldest_q)),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_raddr = issue_q[SLOT_W-1:0];
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = prev_slot;
				if (accept) begin
					priority case (opcode)
						OP_TAP:   state_d = ST_GAP;
						OP_CLEAR: state_d = ST_OUT;
						default:  state_d = ST_SCAN;
					endcase
				end
			end
			ST_GAP: begin
				ram_we  = gap_ok;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (rsp_v_s1 && rsp_slot_s1 == SLOT_W'(HIST_DEPTH - 1)) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				div_start = rate_ok;
				state_d   = rate_ok ? ST_DIV : ST_FLAG;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FLAG;
				end
			end
			ST_FLAG: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= CFG_W'(1000);
			min_gap_q <= CFG_W'(30);
			on_lvl_q  <= CFG_W'(80);
			off_lvl_q <= CFG_W'(50);
			decay_q   <= CFG_W'(1000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW:  window_q  <= cfg_data;
				CFG_MIN_GAP: min_gap_q <= cfg_data;
				CFG_ON_LVL:  on_lvl_q  <= cfg_data;
				CFG_OFF_LVL: off_lvl_q <= cfg_data;
				CFG_DECAY:   decay_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			vld_q       <= '0;
			rate_q      <= '0;
			flag_q      <= 1'b0;
			since_q     <= '0;
			rsp_v_s1    <= 1'b0;
			issue_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rsp_v_s1 <= (state_q == ST_SCAN) && issue_more;
			if (state_q == ST_IDLE && accept) begin
				issue_q <= '0;
				if (opcode == OP_CLEAR) begin
					slot_q  <= '0;
					vld_q   <= '0;
					rate_q  <= '0;
					since_q <= '0;
				end
			end
			if (ram_we) begin
				vld_q[slot_q] <= 1'b1;
				slot_q        <= next_slot;
			end
			if (state_q == ST_SCAN && issue_more) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (state_q == ST_CALC && !rate_ok) begin
				rate_q <= '0;
			end
			if (state_q == ST_DIV && div_done) begin
				rate_q <= (|div_quot[NUM_W-1:16]) ? 16'hFFFF : div_quot[15:0];
			end
			if (state_q == ST_FLAG) begin
				if (rate_q >= on_lvl_q) begin
					since_q <= now_q;
					flag_q  <= 1'b1;
				end else if (flag_q && rate_q < off_lvl_q &&
						STAMP_W'(now_q - since_q) >= {16'd0, decay_q}) begin
					flag_q <= 1'b0;
				end
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			op_q     <= opcode;
			now_q    <= now_ms;
			cnt_q    <= '0;
			oldest_q <= now_ms;
			stored_q <= 1'b0;
		end
		if (state_q == ST_GAP) begin
			stored_q <= gap_ok;
		end
		if (state_q == ST_SCAN && issue_more) begin
			rsp_slot_s1 <= issue_q[SLOT_W-1:0];
		end
		if (rsp_v_s1 && scan_hit) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (scan_stamp < oldest_q) begin
				oldest_q <= scan_stamp;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			rate_out_q   <= rate_q;
			flag_out_q   <= flag_q;
			stored_out_q <= stored_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign rate_x10   = rate_out_q;
	assign fast_flag  = flag_out_q;
	assign tap_stored = stored_out_q;

	a_write_on_tap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_GAP && op_q == OP_TAP)
		else $error("ring written outside a tap");

	a_rsp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_s1 |-> state_q == ST_SCAN)
		else $error("scan response outside scan");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && op_q == OP_CLEAR |-> rate_q == '0 && !stored_q)
		else $error("clear result carries a rate or a stored tap");

endmodule

/* rtl/core/trm_ram.sv */
module trm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/trm_div.sv */
module trm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [trm_pkg::NUM_W-1:0]   num,
	input  logic [trm_pkg::STAMP_W-1:0] den,
	output logic                        done,
	output logic [trm_pkg::NUM_W-1:0]   quot
);

	import trm_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [NUM_W-1:0]    quot_q;
	logic [STAMP_W-1:0]  rem_q;
	logic [STAMP_W-1:0]  den_q;
	logic [STAMP_W:0]    trial;
	logic                fits;

	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= STAMP_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[STAMP_W-1:0];
			end
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_busy_steps: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q != '0)
		else $error("divider busy with no steps left");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

/* verif/tb.sv */
module tb;
	import trm_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic [15:0] rate;
		logic        fast;
		logic        stored;
	} meter_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode = OP_TICK;
	logic [STAMP_W-1:0]   now_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [15:0]          rate_x10;
	logic                 fast_flag;
	logic                 tap_stored;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic [STAMP_W-1:0] tap_log [HIST_DEPTH] = '{default: '0};
	logic [SLOT_W-1:0]  next_slot = '0;
	logic [15:0]        cur_rate = '0;
	logic               fast_on = 1'b0;
	logic [STAMP_W-1:0] fast_mark = '0;
	logic [15:0]        win_ms = 16'd1000;
	logic [15:0]        gap_ms = 16'd30;
	logic [15:0]        on_lvl = 16'd80;
	logic [15:0]        off_lvl = 16'd50;
	logic [15:0]        decay_len = 16'd1000;

	meter_word_t        pending_words[$];
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	logic               hold_req = 1'b0;
	logic               held = 1'b0;
	logic [STAMP_W-1:0] clock_ms = 32'd10000;

	tap_rate_meter_with_hysteresis dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rate_x10(rate_x10),
		.fast_flag(fast_flag),
		.tap_stored(tap_stored),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic meter_word_t predict_word(logic [1:0] op, logic [STAMP_W-1:0] t);
		meter_word_t        w;
		logic [SLOT_W-1:0]  prev;
		logic [31:0]        hits;
		logic [STAMP_W-1:0] oldest;
		logic [31:0]        quot;
		w = '0;
		if (op == OP_CLEAR) begin
			foreach (tap_log[i])
				tap_log[i] = '0;
			next_slot = '0;
			cur_rate = '0;
			fast_mark = '0;
		end else begin
			if (op == OP_TAP) begin
				prev = next_slot - SLOT_W'(1);
				if (tap_log[prev] == '0 || 32'(t - tap_log[prev]) >= 32'(gap_ms)) begin
					tap_log[next_slot] = t;
					next_slot = next_slot + SLOT_W'(1);
					w.stored = 1'b1;
				end
			end
			hits = '0;
			oldest = t;
			foreach (tap_log[i]) begin
				if (tap_log[i] != '0 && 32'(t - tap_log[i]) <= 32'(win_ms)) begin
					hits = hits + 32'd1;
					if (tap_log[i] < oldest)
						oldest = tap_log[i];
				end
			end
			if (hits >= 32'd2 && oldest < t) begin
				quot = ((hits - 32'd1) * 32'(RATE_SCALE)) / 32'(t - oldest);
				cur_rate = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
			end else begin
				cur_rate = '0;
			end
			if (cur_rate >= on_lvl) begin
				fast_mark = t;
				fast_on = 1'b1;
			end else if (fast_on && cur_rate < off_lvl && 32'(t - fast_mark) >= 32'(decay_len)) begin
				fast_on = 1'b0;
			end
		end
		w.rate = cur_rate;
		w.fast = fast_on;
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endtask

	always @(posedge clk) begin
		meter_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word, rate_x10", '0, 32'(rate_x10));
			end else begin
				want = pending_words.pop_front();
				if (rate_x10 !== want.rate)
					report_mismatch("rate_x10", 32'(want.rate), 32'(rate_x10));
				if (fast_flag !== want.fast)
					report_mismatch("fast_flag", 32'(want.fast), 32'(fast_flag));
				if (tap_stored !== want.stored)
					report_mismatch("tap_stored", 32'(want.stored), 32'(tap_stored));
			end
		end
	end

	always @(negedge clk)
		out_stall <= held || ($urandom_range(99) < recv_idle_pct);

	always begin
		wait (hold_req);
		@(posedge clk);
		held = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		held = 1'b0;
		wait (!hold_req);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_word(logic [1:0] op, logic [STAMP_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		now_ms <= t;
		do @(posedge clk); while (in_stall);
		pending_words.push_back(predict_word(op, t));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WINDOW:  win_ms = val;
			CFG_MIN_GAP: gap_ms = val;
			CFG_ON_LVL:  on_lvl = val;
			CFG_OFF_LVL: off_lvl = val;
			CFG_DECAY:   decay_len = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_config(logic [15:0] win, logic [15:0] gap, logic [15:0] on_l,
			logic [15:0] off_l, logic [15:0] dec);
		drain();
		write_reg(CFG_WINDOW, win);
		write_reg(CFG_MIN_GAP, gap);
		write_reg(CFG_ON_LVL, on_l);
		write_reg(CFG_OFF_LVL, off_l);
		write_reg(CFG_DECAY, dec);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_traffic(int count);
		int         pick;
		logic [1:0] op;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 45)
				clock_ms += $urandom_range(20, 250);
			else if (pick < 65)
				clock_ms += $urandom_range(0, 40);
			else if (pick < 85)
				clock_ms += $urandom_range(250, 1500);
			else if (pick < 95)
				clock_ms += $urandom_range(1500, 70000);
			else
				clock_ms = $urandom;
			pick = $urandom_range(99);
			if (pick < 55)
				op = OP_TAP;
			else if (pick < 90)
				op = OP_TICK;
			else if (pick < 95)
				op = OP_CLEAR;
			else
				op = OP_SPARE;
			send_word(op, clock_ms);
		end
	endtask

	task automatic test_empty_ring();
		send_word(OP_TICK, 32'd0);
		send_word(OP_TAP, 32'd0);
		send_word(OP_TAP, 32'd10);
	endtask

	task automatic test_min_gap();
		send_word(OP_TAP, 32'd100);
		send_word(OP_TAP, 32'd110);
		send_word(OP_TAP, 32'd130);
		send_word(OP_TICK, 32'd200);
	endtask

	task automatic test_time_wrap();
		send_word(OP_TAP, 32'hFFFF_FFF0);
		send_word(OP_TAP, 32'hFFFF_FFFF);
		send_word(OP_TICK, 32'h0000_0010);
	endtask

	task automatic test_fast_flag();
		send_word(OP_TAP, 32'd1000);
		send_word(OP_TAP, 32'd1050);
		send_word(OP_TAP, 32'd1100);
		send_word(OP_TICK, 32'd1600);
		send_word(OP_TICK, 32'd2100);
	endtask

	task automatic test_clear_and_spare_op();
		send_word(OP_TAP, 32'd3000);
		send_word(OP_CLEAR, 32'd3010);
		send_word(OP_SPARE, 32'd3020);
		send_word(OP_TAP, 32'd3030);
	endtask

	task automatic test_rate_saturation();
		load_config(16'd1000, 16'd0, 16'd80, 16'd50, 16'd1000);
		repeat (8) send_word(OP_TAP, 32'd5000);
		send_word(OP_TICK, 32'd5001);
	endtask

	task automatic test_register_sweep();
		load_config(16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
		run_traffic(40);
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_traffic(40);
		load_config(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		run_traffic(40);
		load_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
		run_traffic(40);
		load_config(16'd1000, 16'd30, 16'd80, 16'd50, 16'd1000);
		run_traffic(40);
	endtask

	task automatic test_unused_index();
		drain();
		for (int k = CFG_SPARE_LO; k <= CFG_SPARE_HI; k++)
			write_reg(CFG_IDX_W'(k), 16'($urandom));
		cfg_valid <= 1'b0;
		run_traffic(15);
	endtask

	task automatic test_output_hold();
		drain();
		hold_req = 1'b1;
		run_traffic(12);
		drain();
		hold_req = 1'b0;
	endtask

	task automatic test_random_traffic(int s_pct, int r_pct);
		logic [15:0] on_l;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (3) begin
			if ($urandom_range(9) == 0) begin
				load_config(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			end else begin
				on_l = 16'($urandom_range(20, 400));
				load_config(16'($urandom_range(150, 3000)), 16'($urandom_range(0, 120)), on_l,
					16'($urandom_range(0, on_l)), 16'($urandom_range(0, 2500)));
			end
			run_traffic(90);
		end
	endtask

	initial begin
		send_idle_pct = 28;
		recv_idle_pct = 82;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_empty_ring();
		test_min_gap();
		test_time_wrap();
		test_fast_flag();
		test_clear_and_spare_op();
		test_rate_saturation();
		test_register_sweep();
		test_unused_index();
		test_output_hold();
		test_random_traffic(28, 82);
		test_random_traffic(82, 28);
		test_random_traffic(0, 0);
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_words.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
